@@ design/rasr_pkg.sv @@
// Package with payload types and constants for the rational add/subtract block.
package rasr_pkg;
	localparam int OperandW = 16;
	localparam int NumW = 33;
	localparam int DenW = 31;
	localparam int MagW = 64;

	typedef struct packed {
		logic                op;
		logic [OperandW-1:0] num_a;
		logic [OperandW-1:0] den_a;
		logic [OperandW-1:0] num_b;
		logic [OperandW-1:0] den_b;
	} in_word_t;

	typedef struct packed {
		logic [NumW-1:0] result_num;
		logic [DenW-1:0] result_den;
		logic            den_zero;
	} out_word_t;

	// One step of a binary GCD on the pair (u, v) with shared power of two k.
	typedef struct packed {
		logic [MagW-1:0] u;
		logic [MagW-1:0] v;
		logic [6:0]      k;
		logic            done;
	} gcd_cell_t;
endpackage

@@ design/rational_add_sub_reduce_top.sv @@
// Top level of the rational add/subtract block with reduction to lowest terms.
// Each word is handled alone: three fraction reductions run through a chain of
// sixteen binary GCD cells (one step per cell per cycle, recirculating until
// the pair is done), and each reduction with nonzero numerator and denominator
// then divides both by a one-bit-per-cycle divider. The cross products use one
// 64-bit product built from 32x32 partials. in_ready is high only while no word
// is in progress; the result is held in an output register until taken.
module rational_add_sub_reduce_top import rasr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);
	localparam int Cells = 16;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_LOAD = 10'b0000000010,
		ST_GCD  = 10'b0000000100,
		ST_DIVN = 10'b0000001000,
		ST_DIVD = 10'b0000010000,
		ST_NEXT = 10'b0000100000,
		ST_MUL  = 10'b0001000000,
		ST_MACC = 10'b0010000000,
		ST_COMB = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [1:0]      which_q;
	logic [2:0]      mstep_q;
	logic [1:0]      mul_i_q;
	logic [3:0]      pos_q;
	logic            at_end;
	logic            sub_q;
	logic [MagW-1:0] na_q, da_q, nb_q, db_q;
	logic [MagW-1:0] mn_q, md_q;
	logic            neg_q;
	logic [MagW-1:0] g_q;
	logic [MagW-1:0] p_q, q_q, r_q;
	logic [MagW-1:0] prod_q;
	logic [MagW-1:0] ma_q, mb_q;
	logic [31:0]     pa, pb;
	logic [63:0]     pp;

	gcd_cell_t chain [Cells+1];
	gcd_cell_t head;
	logic      chain_en;

	logic            div_start, div_busy;
	logic [MagW-1:0] div_quot;

	function automatic logic [MagW-1:0] sext(input logic [OperandW-1:0] v);
		logic [MagW-1:0] r;
		r = MagW'($signed(v));
		return r;
	endfunction

	function automatic logic [MagW-1:0] absv(input logic [MagW-1:0] v);
		return v[MagW-1] ? (MagW'(0) - v) : v;
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign chain_en = (state_q == ST_GCD);
	assign head     = (state_q == ST_LOAD) ? gcd_cell_t'{u: mn_q, v: md_q, k: '0,
		done: (mn_q == '0) || (md_q == '0)} : chain[Cells];
	assign chain[0] = head;

	// The pair sits at the end of the chain only when the lap position wraps to zero.
	assign at_end = (pos_q == 4'd0) && chain[Cells].done;

	for (genvar i = 0; i < Cells; i++) begin : g_cell
		rasr_gcd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (chain_en || state_q == ST_LOAD),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	rasr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (state_q == ST_DIVN ? mn_q : md_q),
		.divisor  (g_q),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	logic divn_go_q;
	assign div_start = divn_go_q;

	always_comb begin
		unique case (mstep_q[1:0])
			2'd0: begin pa = ma_q[31:0];  pb = mb_q[31:0];  end
			2'd1: begin pa = ma_q[63:32]; pb = mb_q[31:0];  end
			2'd2: begin pa = ma_q[31:0];  pb = mb_q[63:32]; end
			default: begin pa = '0; pb = '0; end
		endcase
	end
	assign pp = pa * pb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			divn_go_q <= 1'b0;
			which_q   <= '0;
			mstep_q   <= '0;
			pos_q     <= '0;
		end else begin
			divn_go_q <= 1'b0;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						which_q <= 2'd0;
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: state_q <= ST_LOAD;
				ST_LOAD: begin
					pos_q   <= 4'd1;
					state_q <= ST_GCD;
				end
				ST_GCD: begin
					pos_q <= pos_q + 4'd1;
					if (at_end) begin
						if (mn_q == '0 || md_q == '0) begin
							state_q <= ST_MUL;
						end else begin
							divn_go_q <= 1'b1;
							state_q   <= ST_DIVN;
						end
					end
				end
				ST_DIVN: begin
					if (!div_busy && !divn_go_q) begin
						divn_go_q <= 1'b1;
						state_q   <= ST_DIVD;
					end
				end
				ST_DIVD: begin
					if (!div_busy && !divn_go_q) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (which_q == 2'd2) begin
						state_q <= ST_OUT;
					end else if (which_q == 2'd1) begin
						mstep_q <= '0;
						state_q <= ST_MACC;
					end else begin
						which_q <= 2'd1;
						state_q <= ST_NEXT;
					end
				end
				ST_MACC: begin
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd3 && mul_i_q == 2'd2) begin
						state_q <= ST_COMB;
					end
					if (mstep_q == 3'd3) begin
						mstep_q <= '0;
					end
				end
				ST_COMB: begin
					which_q <= 2'd2;
					state_q <= ST_NEXT;
				end
				ST_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: operand capture, sign handling, quotient write-back, products and the combining sum or difference.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					sub_q <= in_data.op;
					na_q  <= sext(in_data.num_a);
					da_q  <= sext(in_data.den_a);
					nb_q  <= sext(in_data.num_b);
					db_q  <= sext(in_data.den_b);
				end
			end
			ST_NEXT: begin
				unique case (which_q)
					2'd0: begin
						mn_q  <= absv(na_q);
						md_q  <= absv(da_q);
						neg_q <= na_q[MagW-1] ^ da_q[MagW-1];
					end
					2'd1: begin
						mn_q  <= absv(nb_q);
						md_q  <= absv(db_q);
						neg_q <= nb_q[MagW-1] ^ db_q[MagW-1];
					end
					default: begin
						mn_q  <= absv(r_q);
						md_q  <= absv(prod_q);
						neg_q <= r_q[MagW-1] ^ prod_q[MagW-1];
					end
				endcase
			end
			ST_GCD: begin
				if (at_end) begin
					g_q <= chain[Cells].u << chain[Cells].k;
				end
			end
			ST_DIVN: begin
				if (!div_busy && !divn_go_q) begin
					mn_q <= div_quot;
				end
			end
			ST_DIVD: begin
				if (!div_busy && !divn_go_q) begin
					md_q <= div_quot;
				end
			end
			ST_MUL: begin
				unique case (which_q)
					2'd0: begin
						na_q <= neg_q ? (MagW'(0) - mn_q) : mn_q;
						da_q <= md_q;
					end
					2'd1: begin
						nb_q <= neg_q ? (MagW'(0) - mn_q) : mn_q;
						db_q <= md_q;
						ma_q <= na_q;
						mb_q <= md_q;
						p_q  <= na_q;
						mul_i_q <= 2'd0;
						prod_q <= '0;
					end
					default: begin
						r_q  <= neg_q ? (MagW'(0) - mn_q) : mn_q;
						md_q <= md_q;
					end
				endcase
			end
			ST_MACC: begin
				unique case (mstep_q)
					3'd0: prod_q <= pp;
					3'd1: prod_q <= prod_q + {pp[31:0], 32'd0};
					3'd2: prod_q <= prod_q + {pp[31:0], 32'd0};
					default: begin
						unique case (mul_i_q)
							2'd0: begin
								p_q <= prod_q;
								ma_q <= nb_q; mb_q <= da_q;
								mul_i_q <= 2'd1;
							end
							2'd1: begin
								q_q <= prod_q;
								ma_q <= da_q; mb_q <= db_q;
								mul_i_q <= 2'd2;
							end
							default: ;
						endcase
					end
				endcase
			end
			ST_COMB: begin
				if (da_q == db_q) begin
					r_q    <= sub_q ? (na_q - nb_q) : (na_q + nb_q);
					prod_q <= da_q;
				end else begin
					r_q    <= sub_q ? (p_q - q_q) : (p_q + q_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && !out_valid) begin
			out_data.result_num <= neg_q ? NumW'(MagW'(0) - mn_q) : NumW'(mn_q);
			out_data.result_den <= DenW'(md_q);
			out_data.den_zero   <= (md_q == '0);
		end
	end
endmodule

@@ design/rasr_gcd_cell.sv @@
// One binary GCD step cell: holds a pair and passes the next pair to its neighbor.
module rasr_gcd_cell import rasr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  gcd_cell_t d,
	output gcd_cell_t q
);
	gcd_cell_t nxt;
	logic [MagW-1:0] diff;

	always_comb begin
		nxt = d;
		diff = '0;
		if (!d.done) begin
			if (d.v == '0) begin
				nxt.done = 1'b1;
			end else if (!d.u[0] && !d.v[0]) begin
				nxt.u = d.u >> 1;
				nxt.v = d.v >> 1;
				nxt.k = d.k + 7'd1;
			end else if (!d.u[0]) begin
				nxt.u = d.u >> 1;
			end else if (!d.v[0]) begin
				nxt.v = d.v >> 1;
			end else if (d.u >= d.v) begin
				diff = d.u - d.v;
				nxt.u = diff >> 1;
			end else begin
				diff = d.v - d.u;
				nxt.v = diff >> 1;
			end
			if (nxt.u == '0) begin
				nxt.u = nxt.v;
				nxt.v = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end
endmodule

@@ design/rasr_divider.sv @@
// Restoring divider that takes one quotient bit per cycle.
module rasr_divider import rasr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MagW-1:0] dividend,
	input  logic [MagW-1:0] divisor,
	output logic            busy,
	output logic [MagW-1:0] quotient
);
	logic [MagW-1:0] rem_q;
	logic [MagW-1:0] dvs_q;
	logic [6:0]      cnt_q;
	logic [MagW:0]   trial;

	assign trial = {rem_q, quotient[MagW-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 7'(MagW);
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= '0;
			dvs_q    <= divisor;
			quotient <= dividend;
		end else if (busy) begin
			if (!trial[MagW]) begin
				rem_q    <= trial[MagW-1:0];
				quotient <= {quotient[MagW-2:0], 1'b1};
			end else begin
				rem_q    <= {rem_q[MagW-2:0], quotient[MagW-1]};
				quotient <= {quotient[MagW-2:0], 1'b0};
			end
		end
	end
endmodule

@@ design/rasr_checker.sv @@
// Port-level checker for the rational add/subtract block, with its bind.
module rasr_checker import rasr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Result word changed while stalled.");
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.den_zero == (out_data.result_den == '0)))
		else $error("Zero-denominator flag disagrees with denominator.");
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Second word taken while one is in progress.");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid || $past(out_valid))
		else $error("Result appeared right after acceptance.");
endmodule

bind rational_add_sub_reduce_top rasr_checker u_rasr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
